[sv/pxu_pkg.sv]
// package for the pixel unpack unit: format codes, result type and channel conversions
`default_nettype none
package pxu_pkg;

  localparam int WordWidth = 64;
  localparam int ChanWidth = 18;
  localparam int CfgDataWidth = 32;
  localparam int CfgAddrWidth = 3;

  typedef enum logic [3:0] {
    FMT_ARGB8888 = 4'd0,
    FMT_BGRA8888 = 4'd1,
    FMT_ARGB1555 = 4'd2,
    FMT_ARGB4444 = 4'd3,
    FMT_RGB565   = 4'd4,
    FMT_L8       = 4'd5,
    FMT_A8       = 4'd6,
    FMT_I8       = 4'd7,
    FMT_A8L8     = 4'd8,
    FMT_SRGBA16  = 4'd9,
    FMT_Z16      = 4'd10,
    FMT_Z32      = 4'd11,
    FMT_S8Z24    = 4'd12,
    FMT_Z24S8    = 4'd13
  } pixel_format_t;

  localparam logic [0:0] REG_PIXEL_FORMAT = 1'b0;

  localparam logic [ChanWidth-1:0] Q_ONE  = 18'd65536;
  localparam logic [ChanWidth-1:0] Q_ZERO = 18'd0;

  // alpha first so red sits in the lowest bits
  typedef struct packed {
    logic [ChanWidth-1:0] alpha;
    logic [ChanWidth-1:0] blue;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] red;
  } rgba_t;

  // p holds the first 17 bits of x/(2^n-1) written as a repeating binary fraction;
  // rounding to 16 bits is one add of the 17th bit
  function automatic logic [ChanWidth-1:0] q16_round(input logic [16:0] p);
    logic [ChanWidth-1:0] s;
    s = {1'b0, p} + 18'd1;
    return s >> 1;
  endfunction

  function automatic logic [ChanWidth-1:0] unorm1(input logic x);
    return q16_round({17{x}});
  endfunction

  function automatic logic [ChanWidth-1:0] unorm4(input logic [3:0] x);
    return q16_round({x, x, x, x, x[3]});
  endfunction

  function automatic logic [ChanWidth-1:0] unorm5(input logic [4:0] x);
    return q16_round({x, x, x, x[4:3]});
  endfunction

  function automatic logic [ChanWidth-1:0] unorm6(input logic [5:0] x);
    return q16_round({x, x, x[5:1]});
  endfunction

  function automatic logic [ChanWidth-1:0] unorm8(input logic [7:0] x);
    return q16_round({x, x, x[7]});
  endfunction

  function automatic logic [ChanWidth-1:0] unorm16(input logic [15:0] x);
    return q16_round({x, x[15]});
  endfunction

  function automatic logic [ChanWidth-1:0] unorm24(input logic [23:0] x);
    return q16_round(x[23:7]);
  endfunction

  function automatic logic [ChanWidth-1:0] unorm32(input logic [31:0] x);
    return q16_round(x[31:15]);
  endfunction

  // (2s+1)/65535: magnitude of 2s+1 is {s^sign, 1}, rounded symmetrically
  function automatic logic [ChanWidth-1:0] snorm16(input logic [15:0] x);
    logic [15:0] mag;
    logic [ChanWidth-1:0] r;
    mag = {x[14:0] ^ {15{x[15]}}, 1'b1};
    r = q16_round({mag, mag[15]});
    return x[15] ? (~r + 18'd1) : r;
  endfunction

  function automatic rgba_t unpack_pixel(input logic [3:0] fmt,
                                         input logic [WordWidth-1:0] w);
    rgba_t c;
    logic [ChanWidth-1:0] v;
    c = '0;
    v = '0;
    case (fmt)
      FMT_ARGB8888: begin
        c.red = unorm8(w[23:16]); c.green = unorm8(w[15:8]);
        c.blue = unorm8(w[7:0]);  c.alpha = unorm8(w[31:24]);
      end
      FMT_BGRA8888: begin
        c.red = unorm8(w[15:8]);   c.green = unorm8(w[23:16]);
        c.blue = unorm8(w[31:24]); c.alpha = unorm8(w[7:0]);
      end
      FMT_ARGB1555: begin
        c.red = unorm5(w[14:10]); c.green = unorm5(w[9:5]);
        c.blue = unorm5(w[4:0]);  c.alpha = unorm1(w[15]);
      end
      FMT_ARGB4444: begin
        c.red = unorm4(w[11:8]); c.green = unorm4(w[7:4]);
        c.blue = unorm4(w[3:0]); c.alpha = unorm4(w[15:12]);
      end
      FMT_RGB565: begin
        c.red = unorm5(w[15:11]); c.green = unorm6(w[10:5]);
        c.blue = unorm5(w[4:0]);  c.alpha = Q_ONE;
      end
      FMT_L8: begin
        v = unorm8(w[7:0]);
        c.red = v; c.green = v; c.blue = v; c.alpha = Q_ONE;
      end
      FMT_A8: begin
        c.red = Q_ZERO; c.green = Q_ZERO; c.blue = Q_ZERO; c.alpha = unorm8(w[7:0]);
      end
      FMT_I8: begin
        v = unorm8(w[7:0]);
        c.red = v; c.green = v; c.blue = v; c.alpha = v;
      end
      FMT_A8L8: begin
        v = unorm8(w[7:0]);
        c.red = v; c.green = v; c.blue = v; c.alpha = unorm8(w[15:8]);
      end
      FMT_SRGBA16: begin
        c.red = snorm16(w[15:0]);   c.green = snorm16(w[31:16]);
        c.blue = snorm16(w[47:32]); c.alpha = snorm16(w[63:48]);
      end
      FMT_Z16: begin
        v = unorm16(w[15:0]);
        c.red = v; c.green = v; c.blue = v; c.alpha = v;
      end
      FMT_Z32: begin
        v = unorm32(w[31:0]);
        c.red = v; c.green = v; c.blue = v; c.alpha = v;
      end
      FMT_S8Z24: begin
        v = unorm24(w[23:0]);
        c.red = v; c.green = v; c.blue = v; c.alpha = v;
      end
      FMT_Z24S8: begin
        v = unorm24(w[31:8]);
        c.red = v; c.green = v; c.blue = v; c.alpha = v;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/pixel_unpack_to_rgba_unit.sv]
// pixel unpack unit: packed pixel word in, four signed q1.16 channels out
`default_nettype none
// Converts one packed pixel word per transfer into red, green, blue and alpha
// as signed Q1.16 values (65536 is 1.0), following the layout held in the
// pixel_format register (byte address 0 of the APB port, bits 3:0). Unsigned
// fields become round(x/(2^n-1)), signed 16-bit fields round((2s+1)/65535),
// missing channels 0 or 1.0, depth formats are copied to all four channels,
// and codes 14 and 15 give all zeros. The unit takes one transfer every clock
// while s_tready is high. A result passes through the input register and then
// the result register, with the conversion itself between them. Both stages
// hold their data under backpressure, so while a result waits the input side
// takes a transfer only if the input stage is empty. Change pixel_format only
// while no transfer is in flight.
module pixel_unpack_to_rgba_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input stream
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [pxu_pkg::WordWidth-1:0]         s_tdata,  // pixel_word
  // result stream
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [4*pxu_pkg::ChanWidth-1:0]            m_tdata,  // red_out, green_out,
                                                               // blue_out, alpha_out
  // configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [pxu_pkg::CfgAddrWidth-1:0]      paddr,
  input  wire logic [pxu_pkg::CfgDataWidth-1:0]      pwdata,
  output logic [pxu_pkg::CfgDataWidth-1:0]           prdata,
  output logic                                       pready
);
  import pxu_pkg::*;

  // format register
  logic [3:0] pixel_format;

  // input stage
  logic                 s1_valid;
  logic [WordWidth-1:0] s1_word;
  logic [3:0]           s1_format;

  // conversion result between the stages
  rgba_t result;

  logic out_en;  // result register can load this cycle
  logic s1_en;   // input stage can load this cycle

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register index is the address above the byte offset
  always_comb begin
    if (paddr[2] == REG_PIXEL_FORMAT) begin
      prdata = {{(CfgDataWidth-4){1'b0}}, pixel_format};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_ARGB8888;
    end else if (cfg_write && paddr[2] == REG_PIXEL_FORMAT) begin
      pixel_format <= pwdata[3:0];
    end
  end

  // result register moves when empty or drained; input stage when it can hand over
  assign out_en   = !m_tvalid || m_tready;
  assign s1_en    = !s1_valid || out_en;
  assign s_tready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= s_tvalid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (s1_en && s_tvalid) begin
      s1_word   <= s_tdata;
      s1_format <= pixel_format;
    end
  end

  assign result = unpack_pixel(s1_format, s1_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_en) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      m_tdata <= result;
    end
  end

  // format resets to the first layout
  a_fmt_reset: assert property (@(posedge clk) rst |=> pixel_format == FMT_ARGB8888)
    else $error("pixel_format not cleared by reset");

  // an item in the input stage is moved to the result register when it has room
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_en |=> m_tvalid)
    else $error("item dropped between stages");

  // a full pipe with a stalled output takes nothing new
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while both stages are held");

  // alpha-only layout leaves the color channels at zero
  a_a8_color: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_en && s1_format == FMT_A8 |=> m_tdata[3*ChanWidth-1:0] == '0)
    else $error("color channels not zero for alpha-only layout");

  // the red and alpha channels are never above 1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[ChanWidth-1:0]) <= $signed(Q_ONE))
              && ($signed(m_tdata[4*ChanWidth-1:3*ChanWidth]) <= $signed(Q_ONE)))
    else $error("channel above 1.0");

endmodule
`default_nettype wire
